// ===== rtl/bounded_deque_sorted_list_unit_defines.svh =====
// assertion macros shared by the checker
`ifndef BOUNDED_DEQUE_SORTED_LIST_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_SORTED_LIST_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define BDSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define BDSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdsl_pkg.sv =====
package bdsl_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]              count_t;

  typedef enum logic [2:0] {
    CMD_PUSH_TAIL = 3'd0,
    CMD_POP_TAIL  = 3'd1,
    CMD_PUSH_HEAD = 3'd2,
    CMD_INSERT    = 3'd3,
    CMD_DELETE    = 3'd4,
    CMD_PEEK_TAIL = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] operand_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    status_e            status;
    logic [6:0]         entry_count;
  } out_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE_AT_COUNT,
    OP_SHIFT_IN,
    OP_INSERT,
    OP_DELETE
  } cell_op_e;

  // compare request sent to every cell when an insert or delete is taken
  typedef struct packed {
    logic   en;
    logic   ge;
    value_t value;
    count_t count;
  } probe_t;

  // update request sent to every cell in the execute cycle
  typedef struct packed {
    cell_op_e op;
    value_t   value;
    count_t   count;
  } cell_ctrl_t;

endpackage

// ===== rtl/bdsl_cell.sv =====
module bdsl_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdsl_pkg::count_t      idx_i,
  input  bdsl_pkg::probe_t      probe_i,
  input  bdsl_pkg::cell_ctrl_t  ctrl_i,
  input  bdsl_pkg::value_t      left_i,
  input  bdsl_pkg::value_t      right_i,
  input  logic                  hit_i,
  input  bdsl_pkg::value_t      tail_i,
  output bdsl_pkg::value_t      value_o,
  output logic                  hit_o,
  output bdsl_pkg::value_t      tail_o
);

  bdsl_pkg::value_t value_q, value_d;
  logic             match_q, match_d;
  logic             occupied;
  logic             is_tail;
  logic             at_count;
  logic             cmp;

  assign occupied = idx_i < probe_i.count;
  assign cmp      = probe_i.ge ? (value_q >= probe_i.value) : (value_q == probe_i.value);
  assign match_d  = probe_i.en ? (occupied & cmp) : match_q;

  assign is_tail  = (idx_i + bdsl_pkg::count_t'(1)) == ctrl_i.count;
  assign at_count = idx_i == ctrl_i.count;

  assign hit_o   = hit_i | match_q;
  assign tail_o  = is_tail ? (tail_i | value_q) : tail_i;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      bdsl_pkg::OP_HOLD: ;
      bdsl_pkg::OP_WRITE_AT_COUNT: begin
        if (at_count) begin
          value_d = ctrl_i.value;
        end
      end
      bdsl_pkg::OP_SHIFT_IN: begin
        value_d = left_i;
      end
      bdsl_pkg::OP_INSERT: begin
        if (hit_i) begin
          value_d = left_i;
        end else if (match_q || at_count) begin
          value_d = ctrl_i.value;
        end
      end
      bdsl_pkg::OP_DELETE: begin
        if (hit_i || match_q) begin
          value_d = right_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

endmodule

// ===== rtl/bounded_deque_sorted_list_unit.sv =====
// Ordered list of up to CAPACITY signed words held in a row of cells, head in
// cell 0. For every command, start is taken when busy is low, busy stays
// high for the one execute cycle, and the result shows on result_o with
// result_valid_o for exactly one cycle after it, while busy is already low so
// the next command can be taken in that same cycle. Sorted insert and delete
// compare the operand in every cell at once in the cycle the command is taken
// and shift the cells in the execute cycle. There is no backpressure on the
// result side: a result not taken in its cycle is gone. Stored words are not
// cleared at reset; only the count is.
module bounded_deque_sorted_list_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bdsl_pkg::in_t  item_i,
  output logic           result_valid_o,
  output bdsl_pkg::out_t result_o
);

  localparam int unsigned N = bdsl_pkg::CAPACITY;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e               state_q;
  bdsl_pkg::cmd_e       cmd_q;
  bdsl_pkg::value_t     val_q;
  bdsl_pkg::count_t     count_q, count_d;
  bdsl_pkg::out_t       result_q, result_d;
  logic                 result_valid_q;

  logic                 accept;
  bdsl_pkg::value_t     operand;
  bdsl_pkg::probe_t     probe;
  bdsl_pkg::cell_ctrl_t ctrl;
  logic                 full;
  logic                 empty;
  logic                 found;
  bdsl_pkg::value_t     tail;

  bdsl_pkg::value_t     cell_value [N];
  logic                 cell_hit   [N];
  bdsl_pkg::value_t     cell_tail  [N];

  assign accept  = start && (state_q == S_IDLE);
  assign operand = bdsl_pkg::value_t'(item_i.operand_value);

  assign probe.en    = accept && (item_i.command == bdsl_pkg::CMD_INSERT ||
                                  item_i.command == bdsl_pkg::CMD_DELETE);
  assign probe.ge    = item_i.command == bdsl_pkg::CMD_INSERT;
  assign probe.value = operand;
  assign probe.count = count_q;

  assign full  = count_q == bdsl_pkg::count_t'(N);
  assign empty = count_q == '0;
  assign found = cell_hit[N-1];
  assign tail  = cell_tail[N-1];

  for (genvar i = 0; i < N; i++) begin : g_cell
    bdsl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (bdsl_pkg::count_t'(i)),
      .probe_i (probe),
      .ctrl_i  (ctrl),
      .left_i  ((i == 0) ? val_q : cell_value[(i == 0) ? 0 : i-1]),
      .right_i ((i == N-1) ? bdsl_pkg::value_t'(0) : cell_value[(i == N-1) ? i : i+1]),
      .hit_i   ((i == 0) ? 1'b0 : cell_hit[(i == 0) ? 0 : i-1]),
      .tail_i  ((i == 0) ? bdsl_pkg::value_t'(0) : cell_tail[(i == 0) ? 0 : i-1]),
      .value_o (cell_value[i]),
      .hit_o   (cell_hit[i]),
      .tail_o  (cell_tail[i])
    );
  end

  always_comb begin
    ctrl.op     = bdsl_pkg::OP_HOLD;
    ctrl.value  = val_q;
    ctrl.count  = count_q;
    count_d     = count_q;
    result_d.result_value = '0;
    result_d.status       = bdsl_pkg::ST_OK;
    if (state_q == S_EXEC) begin
      case (cmd_q)
        bdsl_pkg::CMD_PUSH_TAIL, bdsl_pkg::CMD_PUSH_HEAD, bdsl_pkg::CMD_INSERT: begin
          if (full) begin
            result_d.status = bdsl_pkg::ST_FULL;
          end else begin
            count_d = count_q + bdsl_pkg::count_t'(1);
            case (cmd_q)
              bdsl_pkg::CMD_PUSH_TAIL: ctrl.op = bdsl_pkg::OP_WRITE_AT_COUNT;
              bdsl_pkg::CMD_PUSH_HEAD: ctrl.op = bdsl_pkg::OP_SHIFT_IN;
              default:                 ctrl.op = bdsl_pkg::OP_INSERT;
            endcase
          end
        end
        bdsl_pkg::CMD_POP_TAIL, bdsl_pkg::CMD_PEEK_TAIL: begin
          if (empty) begin
            result_d.status = bdsl_pkg::ST_EMPTY;
          end else begin
            result_d.result_value = 32'($unsigned(tail));
            if (cmd_q == bdsl_pkg::CMD_POP_TAIL) begin
              count_d = count_q - bdsl_pkg::count_t'(1);
            end
          end
        end
        bdsl_pkg::CMD_DELETE: begin
          if (found) begin
            ctrl.op = bdsl_pkg::OP_DELETE;
            count_d = count_q - bdsl_pkg::count_t'(1);
          end else begin
            result_d.status = bdsl_pkg::ST_MISSING;
          end
        end
        default: ;
      endcase
    end
    result_d.entry_count = 7'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i.command;
      val_q <= operand;
    end
    if (state_q == S_EXEC) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          count_q        <= count_d;
          result_valid_q <= 1'b1;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = state_q == S_EXEC;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ===== rtl/bdsl_checker.sv =====
`include "bounded_deque_sorted_list_unit_defines.svh"

module bdsl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           result_valid_o,
  input bdsl_pkg::out_t result_o
);

  `BDSL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item taken but busy not raised")
  `BDSL_ASSERT_NEXT(a_busy_result, busy, !busy && result_valid_o, "no result after execute")
  `BDSL_ASSERT_NEXT(a_idle_no_result, !busy, !result_valid_o, "result without an item")
  `BDSL_ASSERT_NOW(a_error_zero, result_valid_o && result_o.status != bdsl_pkg::ST_OK, result_o.result_value == '0, "nonzero value on error")

endmodule

bind bounded_deque_sorted_list_unit bdsl_checker u_bdsl_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import bdsl_pkg::*;

  localparam cmd_e CMD_SPARE_A   = cmd_e'(3'd6);
  localparam cmd_e CMD_SPARE_B   = cmd_e'(3'd7);
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_LIMIT     = 64;
  localparam int SETTLE_CYCLES   = 4;
  localparam int PHASE_ITEMS     = 410;
  localparam value_t VALUE_MAX   = 32'sh7fffffff;
  localparam value_t VALUE_MIN   = 32'sh80000000;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } traffic_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic result_valid_o;
  in_t  item_i = '0;
  out_t result_o;

  value_t shadow_list[$];
  out_t   expected_results[$];
  out_t   oldest_expected;
  int     error_count = 0;
  int     items_sent = 0;
  int     results_checked = 0;
  int     full_hits = 0;
  int     empty_hits = 0;
  int     missing_hits = 0;
  int     peak_fill = 0;
  int     idle_pct = 0;
  int     quiet_cycles = 0;

  bounded_deque_sorted_list_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic out_t list_step(in_t it);
    out_t r;
    int   pos;
    r = '0;
    r.status = ST_OK;
    case (it.command)
      CMD_PUSH_TAIL, CMD_PUSH_HEAD, CMD_INSERT: begin
        if (shadow_list.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (it.command == CMD_PUSH_TAIL) begin
          shadow_list.push_back(it.operand_value);
        end else if (it.command == CMD_PUSH_HEAD) begin
          shadow_list.push_front(it.operand_value);
        end else begin
          pos = 0;
          while (pos < shadow_list.size() && shadow_list[pos] < it.operand_value) pos++;
          shadow_list.insert(pos, it.operand_value);
        end
      end
      CMD_POP_TAIL, CMD_PEEK_TAIL: begin
        if (shadow_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_value = shadow_list[shadow_list.size() - 1];
          if (it.command == CMD_POP_TAIL) void'(shadow_list.pop_back());
        end
      end
      CMD_DELETE: begin
        pos = 0;
        while (pos < shadow_list.size() && shadow_list[pos] != it.operand_value) pos++;
        if (pos < shadow_list.size()) shadow_list.delete(pos);
        else r.status = ST_MISSING;
      end
      default: ;
    endcase
    r.entry_count = 7'(shadow_list.size());
    return r;
  endfunction

  task automatic send_item(input cmd_e cmd, input value_t val);
    in_t it;
    in_t noise;
    int  gap;
    it.command = cmd;
    it.operand_value = val;
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_results.push_back(list_step(it));
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(5, 1);
      noise.command = cmd_e'(3'($urandom_range(7)));
      noise.operand_value = $urandom;
      @(negedge clk_i);
      start  <= 1'b0;
      item_i <= noise;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count += expected_results.size();
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic value_t pick_value(bit prefer_present);
    int roll;
    roll = $urandom_range(99);
    if (prefer_present && shadow_list.size() != 0 && roll < 80)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    if (roll < 35) return value_t'($urandom_range(16)) - 8;
    if (roll < 45) begin
      case ($urandom_range(3))
        0: return VALUE_MAX;
        1: return VALUE_MIN;
        2: return '0;
        default: return -1;
      endcase
    end
    if (roll < 65 && shadow_list.size() != 0)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    return value_t'($urandom);
  endfunction

  function automatic cmd_e pick_command(traffic_mix_e mix);
    int roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (roll < 30) return CMD_PUSH_TAIL;
        if (roll < 55) return CMD_PUSH_HEAD;
        if (roll < 85) return CMD_INSERT;
        if (roll < 90) return CMD_POP_TAIL;
        if (roll < 95) return CMD_PEEK_TAIL;
        if (roll < 98) return CMD_DELETE;
        return $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      end
      MIX_DRAIN: begin
        if (roll < 45) return CMD_POP_TAIL;
        if (roll < 80) return CMD_DELETE;
        if (roll < 90) return CMD_PEEK_TAIL;
        if (roll < 95) return CMD_INSERT;
        return CMD_PUSH_TAIL;
      end
      default: return cmd_e'(3'($urandom_range(7)));
    endcase
  endfunction

  task automatic test_empty_list();
    idle_pct = 0;
    send_item(CMD_POP_TAIL, VALUE_MAX);
    send_item(CMD_PEEK_TAIL, VALUE_MIN);
    send_item(CMD_DELETE, '0);
    send_item(CMD_SPARE_A, -1);
    send_item(CMD_SPARE_B, 32'sh5a5a5a5a);
    wait_for_results();
  endtask

  task automatic test_order_and_extremes();
    idle_pct = 0;
    send_item(CMD_PUSH_TAIL, VALUE_MAX);
    send_item(CMD_PUSH_HEAD, VALUE_MIN);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, VALUE_MAX);
    send_item(CMD_INSERT, VALUE_MIN);
    send_item(CMD_INSERT, '0);
    send_item(CMD_PEEK_TAIL, '0);
    send_item(CMD_DELETE, '0);
    send_item(CMD_DELETE, 32'sh00012345);
    send_item(CMD_SPARE_B, VALUE_MAX);
    send_item(CMD_POP_TAIL, '0);
    send_item(CMD_POP_TAIL, '0);
    // tail now smaller than its neighbor, so the list is out of order
    send_item(CMD_PUSH_TAIL, -5);
    send_item(CMD_INSERT, 3);
    send_item(CMD_DELETE, VALUE_MIN);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int n, input int pct);
    traffic_mix_e mix;
    int           sent;
    int           len;
    cmd_e         cmd;
    sent = 0;
    idle_pct = pct;
    while (sent < n) begin
      mix = traffic_mix_e'($urandom_range(2));
      len = (mix == MIX_ANY) ? $urandom_range(30, 5) : $urandom_range(140, 40);
      if (len > n - sent) len = n - sent;
      repeat (len) begin
        cmd = pick_command(mix);
        send_item(cmd, pick_value(cmd == CMD_DELETE));
        sent++;
      end
    end
    wait_for_results();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending: value %0d status %0d count %0d",
               result_o.result_value, result_o.status, result_o.entry_count);
        error_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        results_checked++;
        if (result_o.result_value !== oldest_expected.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 oldest_expected.result_value, result_o.result_value);
          error_count++;
        end
        if (result_o.status !== oldest_expected.status) begin
          $error("status: expected %0d, got %0d", oldest_expected.status, result_o.status);
          error_count++;
        end
        if (result_o.entry_count !== oldest_expected.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 oldest_expected.entry_count, result_o.entry_count);
          error_count++;
        end
        case (oldest_expected.status)
          ST_FULL:    full_hits++;
          ST_EMPTY:   empty_hits++;
          ST_MISSING: missing_hits++;
          default: ;
        endcase
        if (oldest_expected.entry_count > peak_fill) peak_fill = oldest_expected.entry_count;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_order_and_extremes();
    test_random_traffic(PHASE_ITEMS, 0);
    test_random_traffic(PHASE_ITEMS, 58);
    test_random_traffic(PHASE_ITEMS, 9);
    $display("summary: %0d items sent, %0d results checked, peak fill %0d of %0d",
             items_sent, results_checked, peak_fill, CAPACITY);
    $display("summary: refused when full %0d, empty pop or peek %0d, delete misses %0d",
             full_hits, empty_hits, missing_hits);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== bounded_deque_sorted_list_unit.f =====
+incdir+rtl
rtl/bdsl_pkg.sv
rtl/bdsl_cell.sv
rtl/bounded_deque_sorted_list_unit.sv
rtl/bdsl_checker.sv
tb/sv/tb.sv
